// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mbq_pkg.sv -----
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types, widths and codes of the multichannel biquad filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbq_pkg;

  // default parameter values
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;

  // fixed field and coefficient widths
  localparam int CHAN_BITS     = 3;
  localparam int COEF_BITS     = 32;
  localparam int COEF_FRAC     = 28;
  localparam int OHIST_BITS    = 32;
  localparam int NUM_COEFS     = 5;
  localparam int CFG_ADDR_BITS = 3;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // 1.0 in Q4.28
  localparam coef_t COEF_B0_RESET = coef_t'(32'h1000_0000);

  // coefficient register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  // request kinds
  typedef enum logic {
    REQ_FILTER = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

  // history update control
  typedef struct packed {
    logic wr;
    logic clr;
  } hist_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/multichannel_biquad_filter.sv -----
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// Direct form I biquad with independent history for each audio channel.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the result side stalls. A filtered sample
// is captured in the input register, passes through five parallel multipliers
// and the sum, round and saturate logic, and is written into the result
// register; the channel history is written at the same edge, so a request on
// the same channel may follow in the very next cycle. Clear requests and
// requests on channels at or beyond NUM_CHANNELS pass through the input
// register and give no result. Coefficients are signed Q4.28, already scaled
// by 1/a0; the user must write them only while the block is idle (not checked).
`timescale 1ns / 1ps
`default_nettype none

module multichannel_biquad_filter import mbq_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int DATA_W      = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // coefficient write port
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COEF_BITS-1:0]     cfg_wdata,
  // request stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [DATA_W-1:0]        s_tdata,  // channel, sample_in, zero pad
  input  logic [0:0]               s_tuser,  // req_type
  // result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [DATA_W-1:0]        m_tdata,  // channel_out, sample_out, zero pad
  output logic [0:0]               m_tuser   // clipped
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > CHAN_BITS) ? CNT_W : CHAN_BITS;

  coef_t coef [NUM_COEFS];

  // input register
  logic                          in_v;
  req_type_t                     in_kind;
  logic [CHAN_BITS-1:0]          in_ch;
  logic signed [SAMPLE_BITS-1:0] in_x;

  // result register
  logic                          out_v;
  logic [CHAN_BITS-1:0]          out_ch;
  logic signed [SAMPLE_BITS-1:0] out_y;
  logic                          out_clip;

  logic [CMP_W-1:0]              ch_ext;
  logic                          ch_ok;
  logic                          is_filter;
  logic                          out_free;
  logic                          fire;
  hist_ctl_t                     hctl;
  logic signed [SAMPLE_BITS-1:0] x1, x2;
  logic signed [OHIST_BITS-1:0]  y1, y2;
  logic signed [OHIST_BITS-1:0]  y_hist;
  logic signed [SAMPLE_BITS-1:0] y_out;
  logic                          clip;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[COEF_B0] <= COEF_B0_RESET;
      coef[COEF_B1] <= '0;
      coef[COEF_B2] <= '0;
      coef[COEF_A1] <= '0;
      coef[COEF_A2] <= '0;
    end else if (cfg_we) begin
      unique case (coef_idx_t'(cfg_addr))
        COEF_B0: coef[COEF_B0] <= coef_t'(cfg_wdata);
        COEF_B1: coef[COEF_B1] <= coef_t'(cfg_wdata);
        COEF_B2: coef[COEF_B2] <= coef_t'(cfg_wdata);
        COEF_A1: coef[COEF_A1] <= coef_t'(cfg_wdata);
        COEF_A2: coef[COEF_A2] <= coef_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stage control: only a filtered sample needs room in the result register
  assign ch_ext    = CMP_W'(in_ch);
  assign ch_ok     = ch_ext < CMP_W'(NUM_CHANNELS);
  assign is_filter = in_v && (in_kind == REQ_FILTER) && ch_ok;
  assign out_free  = !out_v || m_tready;
  assign fire      = in_v && (!is_filter || out_free);
  assign s_tready  = !in_v || fire;
  assign hctl.wr   = is_filter && out_free;
  assign hctl.clr  = in_v && (in_kind == REQ_CLEAR) && ch_ok;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= req_type_t'(s_tuser);
      in_ch   <= s_tdata[CHAN_BITS-1:0];
      in_x    <= s_tdata[CHAN_BITS +: SAMPLE_BITS];
    end
  end

  mbq_hist #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .IDX_W        (IDX_W)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .ctl   (hctl),
    .idx   (ch_ext[IDX_W-1:0]),
    .x_new (in_x),
    .y_new (y_hist),
    .x1    (x1),
    .x2    (x2),
    .y1    (y1),
    .y2    (y2)
  );

  mbq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .coef    (coef),
    .x       (in_x),
    .x1      (x1),
    .x2      (x2),
    .y1      (y1),
    .y2      (y2),
    .y_hist  (y_hist),
    .y_out   (y_out),
    .clipped (clip)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (hctl.wr) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hctl.wr) begin
      out_ch   <= in_ch;
      out_y    <= y_out;
      out_clip <= clip;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = DATA_W'({out_y, out_ch});
  assign m_tuser  = out_clip;

endmodule

`default_nettype wire

// ----- hdl/mbq_hist.sv -----
// ----------------------------------------------------------------------------
// mbq_hist
// Per-channel history of the last two inputs and the last two outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbq_hist import mbq_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int IDX_W        = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hist_ctl_t                     ctl,
  input  logic [IDX_W-1:0]              idx,
  input  logic signed [SAMPLE_BITS-1:0] x_new,
  input  logic signed [OHIST_BITS-1:0]  y_new,
  output logic signed [SAMPLE_BITS-1:0] x1,
  output logic signed [SAMPLE_BITS-1:0] x2,
  output logic signed [OHIST_BITS-1:0]  y1,
  output logic signed [OHIST_BITS-1:0]  y2
);

  logic signed [SAMPLE_BITS-1:0] input_hist_1  [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] input_hist_2  [NUM_CHANNELS];
  logic signed [OHIST_BITS-1:0]  output_hist_1 [NUM_CHANNELS];
  logic signed [OHIST_BITS-1:0]  output_hist_2 [NUM_CHANNELS];

  // read the addressed channel
  assign x1 = input_hist_1[idx];
  assign x2 = input_hist_2[idx];
  assign y1 = output_hist_1[idx];
  assign y2 = output_hist_2[idx];

  // shift on a filtered sample, zero on a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        input_hist_1[i]  <= '0;
        input_hist_2[i]  <= '0;
        output_hist_1[i] <= '0;
        output_hist_2[i] <= '0;
      end
    end else if (ctl.clr) begin
      input_hist_1[idx]  <= '0;
      input_hist_2[idx]  <= '0;
      output_hist_1[idx] <= '0;
      output_hist_2[idx] <= '0;
    end else if (ctl.wr) begin
      input_hist_2[idx]  <= input_hist_1[idx];
      input_hist_1[idx]  <= x_new;
      output_hist_2[idx] <= output_hist_1[idx];
      output_hist_1[idx] <= y_new;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mbq_datapath.sv -----
// ----------------------------------------------------------------------------
// mbq_datapath
// Five-tap direct form I sum with rounding and the two saturations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbq_datapath import mbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  coef_t                         coef [NUM_COEFS],
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] x1,
  input  logic signed [SAMPLE_BITS-1:0] x2,
  input  logic signed [OHIST_BITS-1:0]  y1,
  input  logic signed [OHIST_BITS-1:0]  y2,
  output logic signed [OHIST_BITS-1:0]  y_hist,
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output logic                          clipped
);

  localparam int PROD_W = 2 * COEF_BITS;
  localparam int SUM_W  = PROD_W + 3;
  localparam int Y_W    = SUM_W - COEF_FRAC;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [SUM_W-1:0]  acc;
  logic signed [Y_W-1:0]    y;
  logic [Y_W-OHIST_BITS:0]  top_hist;
  logic [Y_W-SAMPLE_BITS:0] top_out;
  logic                     ovf_hist;

  // exact products, operands sign-extended to the product width
  assign p_b0 = PROD_W'(coef[COEF_B0]) * PROD_W'(x);
  assign p_b1 = PROD_W'(coef[COEF_B1]) * PROD_W'(x1);
  assign p_b2 = PROD_W'(coef[COEF_B2]) * PROD_W'(x2);
  assign p_a1 = PROD_W'(coef[COEF_A1]) * PROD_W'(y1);
  assign p_a2 = PROD_W'(coef[COEF_A2]) * PROD_W'(y2);

  // full-precision sum plus half an lsb, then floor
  assign acc = SUM_W'(p_b0) + SUM_W'(p_b1) + SUM_W'(p_b2)
             - SUM_W'(p_a1) - SUM_W'(p_a2) + RND;
  assign y   = acc[SUM_W-1:COEF_FRAC];

  // saturate to 32 bits for the feedback history
  assign top_hist = y[Y_W-1:OHIST_BITS-1];
  assign ovf_hist = !((&top_hist) || !(|top_hist));
  assign y_hist   = ovf_hist ? {y[Y_W-1], {(OHIST_BITS-1){~y[Y_W-1]}}}
                             : y[OHIST_BITS-1:0];

  // saturate to sample width for the result
  assign top_out = y[Y_W-1:SAMPLE_BITS-1];
  assign clipped = !((&top_out) || !(|top_out));
  assign y_out   = clipped ? {y[Y_W-1], {(SAMPLE_BITS-1){~y[Y_W-1]}}}
                           : y[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/mbq_checker.sv -----
// ----------------------------------------------------------------------------
// mbq_checker
// Port-level checks of the multichannel biquad filter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mbq_checker import mbq_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int DATA_W      = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [DATA_W-1:0]        m_tdata,
  input logic [0:0]               m_tuser
);

  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > CHAN_BITS) ? CNT_W : CHAN_BITS;
  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] res_sample;
  logic [CMP_W-1:0]       res_ch;

  assign res_sample = m_tdata[CHAN_BITS +: SAMPLE_BITS];
  assign res_ch     = CMP_W'(m_tdata[CHAN_BITS-1:0]);

  // a stalled result holds
  `ASSERT_RST(a_res_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // no result right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // with the result register empty the block always takes a request
  `ASSERT_RST(a_ready_empty, clk, rst, !m_tvalid |-> s_tready, "request refused with empty output")

  // a clipped sample sits at one of the two rails
  `ASSERT_RST(a_clip_rail, clk, rst, m_tvalid && m_tuser[0] |-> (res_sample == SAT_HI) || (res_sample == SAT_LO), "clip flag off rail")

  // results only for channels that exist
  `ASSERT_RST(a_res_chan, clk, rst, m_tvalid |-> res_ch < CMP_W'(NUM_CHANNELS), "result on missing channel")

endmodule

bind multichannel_biquad_filter mbq_checker #(
  .NUM_CHANNELS (NUM_CHANNELS),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_mbq_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel biquad filter.
// ----------------------------------------------------------------------------
// A queue of filter and clear requests feeds a stream driver with random
// gaps, while the result side stalls at random. Every accepted request runs
// through a bit-exact biquad model with its own channel history and
// coefficient copy. Every result is compared field by field against the
// oldest predicted sample. Coefficients start at their reset values and are
// reloaded between phases while the block is idle: exact halves for rounding
// ties, full-scale extremes, and random settings.
`timescale 1ns / 1ps

module tb;
  import mbq_pkg::*;

  localparam int CHANNELS    = NUM_CHANNELS_DEF;
  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int DATA_W      = ((CHAN_BITS + SAMPLE_W + 7) / 8) * 8;
  localparam int ACC_W       = 67;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DRAIN  = 4;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 170;
  localparam int MAX_REPORTS = 50;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam coef_t COEF_MAX  = 32'sh7fff_ffff;
  localparam coef_t COEF_MIN  = 32'sh8000_0000;
  localparam coef_t COEF_HALF = 32'sh0800_0000;

  typedef logic signed [ACC_W-1:0] wide_t;

  typedef struct packed {
    req_type_t                   kind;
    logic [CHAN_BITS-1:0]        chan;
    logic signed [SAMPLE_W-1:0]  smp;
  } biquad_req_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]        chan;
    logic signed [SAMPLE_W-1:0]  smp;
    logic                        clip;
  } biquad_out_t;

  // dut signals
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [COEF_BITS-1:0]     cfg_wdata = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [DATA_W-1:0]        s_tdata = '0;  // channel, sample_in, zero pad
  logic [0:0]               s_tuser = '0;  // req_type
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [DATA_W-1:0]        m_tdata;  // channel_out, sample_out, zero pad
  logic [0:0]               m_tuser;  // clipped

  // filter model state
  coef_t                      coef_q [NUM_COEFS];
  logic signed [SAMPLE_W-1:0] x_hist1 [CHANNELS];
  logic signed [SAMPLE_W-1:0] x_hist2 [CHANNELS];
  logic signed [OHIST_BITS-1:0] y_hist1 [CHANNELS];
  logic signed [OHIST_BITS-1:0] y_hist2 [CHANNELS];

  biquad_req_t sample_requests[$];
  biquad_out_t predicted_outputs[$];

  int  issued_total   = 0;
  int  accepted_total = 0;
  int  clears_seen    = 0;
  int  samples_checked = 0;
  int  clipped_seen   = 0;
  int  coef_settings  = 0;
  int  errors         = 0;
  int  cycle_count    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  bit  req_taken      = 1'b0;
  bit  out_taken      = 1'b0;
  bit  src_pause_on   = 1'b1;
  bit  snk_pause_on   = 1'b1;

  multichannel_biquad_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still expected",
               cycle_count, predicted_outputs.size());
      $display("tb: failure");
      $finish;
    end
  end

  // clamp to a signed width
  function automatic wide_t clamp(input wide_t v, input int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one direct form I step on a channel, updates its history
  function automatic biquad_out_t biquad_step(input logic [CHAN_BITS-1:0] ch,
                                              input logic signed [SAMPLE_W-1:0] x);
    wide_t       acc;
    wide_t       y;
    wide_t       y_smp;
    wide_t       y_wide;
    biquad_out_t res;
    acc = coef_q[COEF_B0] * x
        + coef_q[COEF_B1] * x_hist1[ch]
        + coef_q[COEF_B2] * x_hist2[ch]
        - coef_q[COEF_A1] * y_hist1[ch]
        - coef_q[COEF_A2] * y_hist2[ch];
    // round half up, drop the fraction
    y = (acc + (wide_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    y_smp = clamp(y, SAMPLE_W);
    y_wide = clamp(y, OHIST_BITS);
    res.chan = ch;
    res.smp  = y_smp[SAMPLE_W-1:0];
    res.clip = (y_smp != y);
    x_hist2[ch] = x_hist1[ch];
    x_hist1[ch] = x;
    y_hist2[ch] = y_hist1[ch];
    y_hist1[ch] = y_wide[OHIST_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    if (errors < MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               field, cycle_count, got, want);
    errors++;
  endtask

  // result check first, then prediction of the newly accepted request
  always @(posedge clk) begin : track
    biquad_out_t want;
    biquad_req_t r;
    out_taken = 1'b0;
    req_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_taken = 1'b1;
        if (predicted_outputs.size() == 0) begin
          report_mismatch("unexpected result, channel", m_tdata[CHAN_BITS-1:0], -1);
        end else begin
          want = predicted_outputs.pop_front();
          samples_checked++;
          if (want.clip) clipped_seen++;
          if (m_tdata[CHAN_BITS-1:0] !== want.chan)
            report_mismatch("channel_out", m_tdata[CHAN_BITS-1:0], want.chan);
          if ($signed(m_tdata[CHAN_BITS +: SAMPLE_W]) !== want.smp)
            report_mismatch("sample_out", $signed(m_tdata[CHAN_BITS +: SAMPLE_W]),
                            want.smp);
          if (m_tuser[0] !== want.clip)
            report_mismatch("clipped", m_tuser[0], want.clip);
          if (m_tdata[DATA_W-1:CHAN_BITS+SAMPLE_W] !== '0)
            report_mismatch("tdata pad", m_tdata[DATA_W-1:CHAN_BITS+SAMPLE_W], 0);
        end
      end
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        accepted_total++;
        r.kind = req_type_t'(s_tuser[0]);
        r.chan = s_tdata[CHAN_BITS-1:0];
        r.smp  = s_tdata[CHAN_BITS +: SAMPLE_W];
        if (r.kind == REQ_CLEAR) begin
          clears_seen++;
          x_hist1[r.chan] = '0;
          x_hist2[r.chan] = '0;
          y_hist1[r.chan] = '0;
          y_hist2[r.chan] = '0;
        end else begin
          predicted_outputs.push_back(biquad_step(r.chan, r.smp));
        end
      end
    end
  end

  // request driver with random gaps
  always @(negedge clk) begin : drive_req
    biquad_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_requests.size() != 0) begin
        r = sample_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W-CHAN_BITS-SAMPLE_W){1'b0}}, r.smp, r.chan};
        s_tuser  <= r.kind;
        gap_left = src_pause_on ? $urandom_range(0, 3) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_taken) stall_left = snk_pause_on ? $urandom_range(0, 3) : 0;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_req(input req_type_t kind, input int ch,
                           input logic signed [SAMPLE_W-1:0] smp);
    biquad_req_t r;
    r.kind = kind;
    r.chan = CHAN_BITS'(ch);
    r.smp  = smp;
    sample_requests.push_back(r);
    issued_total++;
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] idx, input coef_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NUM_COEFS) coef_q[idx] = val;
  endtask

  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t a1, input coef_t a2);
    cfg_write(COEF_B0, b0);
    cfg_write(COEF_B1, b1);
    cfg_write(COEF_B2, b2);
    cfg_write(COEF_A1, a1);
    cfg_write(COEF_A2, a2);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    coef_settings++;
  endtask

  // block idle: all requests taken, all samples back, pipeline flushed
  task automatic wait_idle;
    do @(negedge clk);
    while (accepted_total != issued_total || predicted_outputs.size() != 0);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample;
    case ($urandom_range(0, 5))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef;
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      // within +-2.0, the usual range of a stable section
      3, 4, 5: return coef_t'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      default: return coef_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int narrow;
    coef_q[COEF_B0] = COEF_B0_RESET;
    for (int i = 1; i < NUM_COEFS; i++) coef_q[i] = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      x_hist1[c] = '0;
      x_hist2[c] = '0;
      y_hist1[c] = '0;
      y_hist2[c] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients pass samples through unchanged
    queue_req(REQ_FILTER, 0, SMP_MAX);
    queue_req(REQ_FILTER, 7, SMP_MIN);
    queue_req(REQ_FILTER, 5, '0);
    queue_req(REQ_FILTER, 2, -1);
    queue_req(REQ_FILTER, 0, 1);
    queue_req(REQ_CLEAR, 0, 24'sh555555);
    queue_req(REQ_FILTER, 0, 24'sh2aaaaa);
    wait_idle();

    // exact half gain: rounding ties, unused register indexes ignored
    for (int k = 0; k < (1 << CFG_ADDR_BITS) - NUM_COEFS; k++)
      cfg_write(CFG_ADDR_BITS'(NUM_COEFS + k), COEF_MIN);
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    queue_req(REQ_FILTER, 1, 1);
    queue_req(REQ_FILTER, 1, -1);
    queue_req(REQ_FILTER, 1, 3);
    queue_req(REQ_FILTER, 1, -3);
    wait_idle();

    // full-scale taps: output clipping and 32-bit history saturation
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN);
    repeat (4) queue_req(REQ_FILTER, 4, SMP_MAX);
    queue_req(REQ_FILTER, 6, SMP_MIN);
    queue_req(REQ_FILTER, 6, SMP_MIN);
    queue_req(REQ_CLEAR, 4, SMP_MIN);
    queue_req(REQ_FILTER, 4, SMP_MAX);
    wait_idle();

    // random phases, one coefficient setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        1: load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        default: load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef());
      endcase
      src_pause_on = (p % 4 != 3) && ($urandom_range(0, 3) != 0);
      snk_pause_on = (p % 4 != 2) && ($urandom_range(0, 3) != 0);
      // some phases hammer two channels to exercise back-to-back requests on the same channel
      narrow = $urandom_range(0, 1);
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_req(($urandom_range(0, 99) < 8) ? REQ_CLEAR : REQ_FILTER,
                  narrow ? $urandom_range(0, 1) : $urandom_range(0, CHANNELS - 1),
                  rand_sample());
      wait_idle();
    end

    $display("covered %0d requests (%0d clears) over %0d coefficient settings",
             accepted_total, clears_seen, coef_settings);
    $display("checked %0d filtered samples, %0d of them clipped, %0d mismatches",
             samples_checked, clipped_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mbq_pkg.sv
hdl/mbq_hist.sv
hdl/mbq_datapath.sv
hdl/multichannel_biquad_filter.sv
hdl/mbq_checker.sv
tb/tb.sv
